/* src/ppsd_pkg.sv */
// ============================================================================
// ppsd_pkg
// Shared types and constants of the position PID controller with stall
// detection.
// ============================================================================
`default_nettype none

package ppsd_pkg;

  localparam int POSITION_WIDTH  = 32;
  localparam int INTEGRAL_WIDTH  = 24;
  localparam int STALL_TICKS     = 15;
  localparam int STALL_ERROR_MIN = 20;
  localparam int STALL_MOVE_MIN  = 5;

  localparam int GAIN_W   = 16;
  localparam int CUR_W    = 12;
  localparam int DRIVE_W  = 8;
  localparam int WINDOW_W = 10;
  localparam int CNT_W    = $clog2(STALL_TICKS + 1);

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_GAIN_P          = 3'd0,
    REG_GAIN_I          = 3'd1,
    REG_GAIN_D          = 3'd2,
    REG_CURRENT_OFFSET  = 3'd3,
    REG_CURRENT_LIMIT   = 3'd4,
    REG_MIN_DRIVE       = 3'd5,
    REG_DEAD_BAND       = 3'd6,
    REG_INTEGRAL_WINDOW = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [CUR_W-1:0]         current_offset;
    logic [CUR_W-1:0]         current_limit;
    logic [DRIVE_W-1:0]       min_drive;
    logic [DRIVE_W-1:0]       dead_band;
    logic [WINDOW_W-1:0]      integral_window;
  } cfg_t;

  typedef struct packed {
    logic signed [POSITION_WIDTH-1:0] position;
    logic signed [POSITION_WIDTH-1:0] target_position;
    logic [DRIVE_W-1:0]               speed_limit;
    logic                             enable;
    logic [CUR_W-1:0]                 current_sample;
  } tick_in_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] duty;
    logic               direction;
    logic               driver_awake;
    logic               stalled;
  } tick_out_t;

endpackage

`default_nettype wire

/* src/ppsd_cfg.sv */
// ============================================================================
// ppsd_cfg
// APB register file holding the gains, current calibration, drive limits
// and the integral window.
// ============================================================================
`default_nettype none

module ppsd_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ppsd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [ppsd_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [ppsd_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  output ppsd_pkg::cfg_t                       cfg
);
  import ppsd_pkg::*;

  reg_idx_t reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p          <= GAIN_W'(256);
      cfg.gain_i          <= '0;
      cfg.gain_d          <= '0;
      cfg.current_offset  <= '0;
      cfg.current_limit   <= CUR_W'(2680);
      cfg.min_drive       <= DRIVE_W'(124);
      cfg.dead_band       <= DRIVE_W'(12);
      cfg.integral_window <= WINDOW_W'(50);
    end else if (wr_en) begin
      case (reg_idx)
        REG_GAIN_P:          cfg.gain_p          <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:          cfg.gain_i          <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:          cfg.gain_d          <= pwdata[GAIN_W-1:0];
        REG_CURRENT_OFFSET:  cfg.current_offset  <= pwdata[CUR_W-1:0];
        REG_CURRENT_LIMIT:   cfg.current_limit   <= pwdata[CUR_W-1:0];
        REG_MIN_DRIVE:       cfg.min_drive       <= pwdata[DRIVE_W-1:0];
        REG_DEAD_BAND:       cfg.dead_band       <= pwdata[DRIVE_W-1:0];
        REG_INTEGRAL_WINDOW: cfg.integral_window <= pwdata[WINDOW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_GAIN_P:          prdata = APB_DATA_W'($unsigned(cfg.gain_p));
      REG_GAIN_I:          prdata = APB_DATA_W'($unsigned(cfg.gain_i));
      REG_GAIN_D:          prdata = APB_DATA_W'($unsigned(cfg.gain_d));
      REG_CURRENT_OFFSET:  prdata = APB_DATA_W'(cfg.current_offset);
      REG_CURRENT_LIMIT:   prdata = APB_DATA_W'(cfg.current_limit);
      REG_MIN_DRIVE:       prdata = APB_DATA_W'(cfg.min_drive);
      REG_DEAD_BAND:       prdata = APB_DATA_W'(cfg.dead_band);
      REG_INTEGRAL_WINDOW: prdata = APB_DATA_W'(cfg.integral_window);
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* src/ppsd_ctrl.sv */
// ============================================================================
// ppsd_ctrl
// Control law of one tick: error, derivative, windowed integral, weighted
// sum, clamping, deadband, stall detection, and the loop state registers.
// ============================================================================
`default_nettype none

module ppsd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  ppsd_pkg::tick_in_t      tick,
  input  ppsd_pkg::cfg_t          cfg,
  output ppsd_pkg::tick_out_t     res
);
  import ppsd_pkg::*;

  localparam int PW    = POSITION_WIDTH;
  localparam int IW    = INTEGRAL_WIDTH;
  localparam int SW    = ((PW > IW) ? PW : IW) + 1;
  localparam int SUM_W = GAIN_W + PW + 3;
  localparam int DW_S  = DRIVE_W + 9;

  localparam logic signed [SW-1:0] IMAX_S = {{(SW-IW+1){1'b0}}, {(IW-1){1'b1}}};
  localparam logic signed [SW-1:0] IMIN_S = {{(SW-IW+1){1'b1}}, {(IW-1){1'b0}}};

  logic signed [PW-1:0]   previous_error, previous_error_next;
  logic signed [IW-1:0]   integral_sum, integral_sum_next;
  logic [CNT_W-1:0]       stall_count, stall_count_next;
  logic signed [PW-1:0]   last_position, last_position_next;
  logic                   stall_latch, stall_latch_next;
  logic [DRIVE_W-1:0]     held_duty, held_duty_next;
  logic                   held_direction, held_direction_next;
  logic                   awake_flag, awake_flag_next;

  logic                   active;
  logic signed [PW:0]     diff;
  logic signed [PW-1:0]   err;
  logic [PW-1:0]          err_neg;
  logic [PW-1:0]          aerr;
  logic signed [PW:0]     der;
  logic signed [SW-1:0]   isum;
  logic signed [IW-1:0]   isat;
  logic signed [IW-1:0]   integ_win;
  logic                   in_window;

  logic signed [GAIN_W+PW-1:0]   prod_p;
  logic signed [GAIN_W+IW-1:0]   prod_i;
  logic signed [GAIN_W+PW:0]     prod_d;
  logic signed [SUM_W-1:0]       sum;

  logic [DRIVE_W-1:0]     lim;
  logic signed [DW_S-1:0] lim_s, lim_neg_s, floor_s, floor_neg_s;
  logic signed [SUM_W-1:0] lim_pos, lim_neg;
  logic signed [DW_S-1:0] s_cl, s_fin, s_neg;
  logic [DW_S-1:0]        s_abs;
  logic                   s_nz;

  logic [CUR_W:0]         cur_diff, cur_neg;
  logic [CUR_W-1:0]       cur_mag;
  logic [PW:0]            mv, mv_neg, mv_mag;
  logic                   little_move, stall_cond, trip, dead;
  logic [CNT_W-1:0]       count_inc;

  assign active = tick.enable & ~stall_latch;

  // Error with saturation to the position range.
  assign diff = {tick.target_position[PW-1], tick.target_position}
              - {tick.position[PW-1], tick.position};
  always_comb begin
    if (diff[PW] != diff[PW-1]) begin
      err = diff[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
    end else begin
      err = diff[PW-1:0];
    end
  end
  assign err_neg = -err;
  assign aerr    = err[PW-1] ? err_neg : err;
  assign der     = {err[PW-1], err} - {previous_error[PW-1], previous_error};

  // Windowed, saturating integral.
  assign isum = {{(SW-IW){integral_sum[IW-1]}}, integral_sum}
              + {{(SW-PW){err[PW-1]}}, err};
  always_comb begin
    if (isum > IMAX_S) begin
      isat = IMAX_S[IW-1:0];
    end else if (isum < IMIN_S) begin
      isat = IMIN_S[IW-1:0];
    end else begin
      isat = isum[IW-1:0];
    end
  end
  assign in_window = aerr < {{(PW-WINDOW_W){1'b0}}, cfg.integral_window};
  assign integ_win = in_window ? isat : '0;

  // Weighted sum of the three terms.
  assign prod_p = cfg.gain_p * err;
  assign prod_i = cfg.gain_i * integ_win;
  assign prod_d = cfg.gain_d * der;
  assign sum    = prod_p + prod_i + prod_d;

  // Clamp to the speed limit, floored by the minimum drive.
  assign lim         = (tick.speed_limit < cfg.min_drive) ? cfg.min_drive : tick.speed_limit;
  assign lim_s       = {1'b0, lim, 8'h00};
  assign lim_neg_s   = -lim_s;
  assign lim_pos     = {{(SUM_W-DW_S){1'b0}}, lim_s};
  assign lim_neg     = -lim_pos;
  assign floor_s     = {1'b0, cfg.min_drive, 8'h00};
  assign floor_neg_s = -floor_s;

  always_comb begin
    if (sum > lim_pos) begin
      s_cl = lim_s;
    end else if (sum < lim_neg) begin
      s_cl = lim_neg_s;
    end else begin
      s_cl = sum[DW_S-1:0];
    end
  end

  // Stall detection.
  assign cur_diff    = {1'b0, tick.current_sample} - {1'b0, cfg.current_offset};
  assign cur_neg     = -cur_diff;
  assign cur_mag     = cur_diff[CUR_W] ? cur_neg[CUR_W-1:0] : cur_diff[CUR_W-1:0];
  assign mv          = {tick.position[PW-1], tick.position}
                     - {last_position[PW-1], last_position};
  assign mv_neg      = -mv;
  assign mv_mag      = mv[PW] ? mv_neg : mv;
  assign little_move = mv_mag < (PW+1)'(STALL_MOVE_MIN);
  assign stall_cond  = (aerr > PW'(STALL_ERROR_MIN)) && (cur_mag > cfg.current_limit);
  assign count_inc   = stall_count + 1'b1;
  assign trip        = stall_cond && little_move && (count_inc >= CNT_W'(STALL_TICKS));
  assign dead        = aerr <= {{(PW-DRIVE_W){1'b0}}, cfg.dead_band};

  // Deadband and minimum-drive lift.
  always_comb begin
    s_fin = s_cl;
    if (trip || dead) begin
      s_fin = '0;
    end else if (s_cl > 0 && s_cl < floor_s) begin
      s_fin = floor_s;
    end else if (s_cl < 0 && s_cl > floor_neg_s) begin
      s_fin = floor_neg_s;
    end
  end
  assign s_neg = -s_fin;
  assign s_abs = s_fin[DW_S-1] ? s_neg : s_fin;
  assign s_nz  = s_fin != '0;

  always_comb begin
    previous_error_next = '0;
    integral_sum_next   = '0;
    stall_count_next    = '0;
    last_position_next  = tick.position;
    stall_latch_next    = tick.enable & stall_latch;
    held_duty_next      = held_duty;
    held_direction_next = held_direction;
    awake_flag_next     = awake_flag;
    if (active) begin
      previous_error_next = err;
      integral_sum_next   = (trip || dead) ? '0 : integ_win;
      if (stall_cond && little_move && !trip) begin
        stall_count_next = count_inc;
      end
      stall_latch_next = trip;
      if (s_nz) begin
        held_duty_next      = s_abs[DRIVE_W+7:8];
        held_direction_next = ~s_fin[DW_S-1];
        awake_flag_next     = 1'b1;
      end else begin
        held_duty_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      integral_sum   <= '0;
      stall_count    <= '0;
      last_position  <= '0;
      stall_latch    <= 1'b0;
      held_duty      <= '0;
      held_direction <= 1'b0;
      awake_flag     <= 1'b0;
    end else if (step) begin
      previous_error <= previous_error_next;
      integral_sum   <= integral_sum_next;
      stall_count    <= stall_count_next;
      last_position  <= last_position_next;
      stall_latch    <= stall_latch_next;
      held_duty      <= held_duty_next;
      held_direction <= held_direction_next;
      awake_flag     <= awake_flag_next;
    end
  end

  assign res.duty         = held_duty_next;
  assign res.direction    = held_direction_next;
  assign res.driver_awake = awake_flag_next;
  assign res.stalled      = stall_latch_next;

  a_count_below_trip: assert property (@(posedge clk) disable iff (rst)
    stall_count < CNT_W'(STALL_TICKS))
    else $error("Stall counter reached the trip count without clearing.");

  a_disable_clears_latch: assert property (@(posedge clk) disable iff (rst)
    step && !tick.enable |=> !stall_latch)
    else $error("Stall latch survived a tick with the loop disabled.");

endmodule

`default_nettype wire

/* src/position_pid_with_stall_detect_core.sv */
// ============================================================================
// position_pid_with_stall_detect_core
// Position PID controller with a stall latch, one control tick per word.
// ============================================================================
// The block takes one input word per clock cycle while the output side is
// not stalled, and returns one result word per input word. A word is
// captured in an input register, the whole control law is evaluated
// combinationally by the control unit, and the result is held in an output
// register; the loop state updates on the edge that loads the output
// register, so the next word sees it with no bubble. The user must write
// configuration through the APB port while no word is in flight; the block
// does not enforce this, and no clearing pass follows reset.
`default_nettype none

module position_pid_with_stall_detect_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [ppsd_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [ppsd_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [ppsd_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                     pready,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [ppsd_pkg::POSITION_WIDTH-1:0] position,
  input  wire logic signed [ppsd_pkg::POSITION_WIDTH-1:0] target_position,
  input  wire logic [ppsd_pkg::DRIVE_W-1:0]        speed_limit,
  input  wire logic                                enable,
  input  wire logic [ppsd_pkg::CUR_W-1:0]          current_sample,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [ppsd_pkg::DRIVE_W-1:0]             duty,
  output logic                                     direction,
  output logic                                     driver_awake,
  output logic                                     stalled
);
  import ppsd_pkg::*;

  cfg_t      cfg;
  tick_in_t  s1_data;
  logic      s1_valid;
  tick_out_t res;
  logic      o_free;
  logic      step;

  ppsd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign o_free   = ~out_valid | out_ready;
  assign step     = s1_valid & o_free;
  assign in_ready = ~s1_valid | o_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data.position        <= position;
      s1_data.target_position <= target_position;
      s1_data.speed_limit     <= speed_limit;
      s1_data.enable          <= enable;
      s1_data.current_sample  <= current_sample;
    end
  end

  ppsd_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .tick (s1_data),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      duty         <= res.duty;
      direction    <= res.direction;
      driver_awake <= res.driver_awake;
      stalled      <= res.stalled;
    end
  end

  a_stall_zero_duty: assert property (@(posedge clk) disable iff (rst)
    out_valid && stalled |-> duty == '0)
    else $error("Nonzero duty reported while the stall latch is set.");

  a_duty_implies_awake: assert property (@(posedge clk) disable iff (rst)
    out_valid && duty != '0 |-> driver_awake)
    else $error("Nonzero duty reported with the driver asleep.");

  a_input_word_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !o_free |=> s1_valid && $stable(s1_data))
    else $error("Input register changed while its word was blocked.");

endmodule

`default_nettype wire
